// ===== rtl/bfm_pkg.sv =====
// shared types and constants of the bit-vector field matcher stage
package bfm_pkg;

	localparam int RULE_SLOTS = 32;
	localparam int CLASS_BITS = 64;
	localparam int KEY_W      = 64;
	localparam int LEN_W      = 7;
	localparam int ENTRY_W    = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int SLOT_W     = ($clog2(RULE_SLOTS) > ENTRY_W) ? $clog2(RULE_SLOTS) : ENTRY_W;

	localparam logic [LEN_W-1:0] KEY_W_RESET = LEN_W'(32);
	localparam logic [LEN_W-1:0] KEY_W_MAX   = LEN_W'(KEY_W);

	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_MODE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WIDTH       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_ENABLE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_BITS   = CFG_IDX_W'(3);

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_WRITE    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		VERDICT_CONTINUE = 2'd0,
		VERDICT_NO_MATCH = 2'd1,
		VERDICT_EMPTY    = 2'd2,
		VERDICT_WRITTEN  = 2'd3
	} verdict_t;

	// flag: entry_valid for a write, hit so far for a classify
	// key/len/bits: rule fields for a write, search key / best prefix / best bits for a classify
	typedef struct packed {
		op_t                    op;
		logic [SLOT_W-1:0]      idx;
		logic                   flag;
		logic [KEY_W-1:0]       key;
		logic [LEN_W-1:0]       len;
		logic [CLASS_BITS-1:0]  bits;
		logic [CLASS_BITS-1:0]  pbits;
	} token_t;

	typedef struct packed {
		logic              prefix_mode;
		logic [LEN_W-1:0]  eff_w;
		logic [KEY_W-1:0]  kmask;
	} match_cfg_t;

endpackage

// ===== rtl/bfm_cell.sv =====
// one rule slot of the matcher chain
module bfm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfm_pkg::SLOT_W-1:0] slot_id,
	input  bfm_pkg::match_cfg_t       cfg,
	input  logic                      in_vld,
	input  bfm_pkg::token_t           in_tok,
	output logic                      out_vld,
	output bfm_pkg::token_t           out_tok
);
	import bfm_pkg::*;

	logic                   valid_q;
	logic [KEY_W-1:0]       key_q;
	logic [LEN_W-1:0]       prefix_q;
	logic [CLASS_BITS-1:0]  bits_q;

	logic                   vld_s1;
	token_t                 tok_s1;

	logic                   wr_hit;
	logic [LEN_W-1:0]       pe;
	logic [LEN_W-1:0]       shift;
	logic [KEY_W-1:0]       cmp_mask;
	logic                   match;
	logic                   take;
	token_t                 nxt_tok;

	assign wr_hit = in_vld && (in_tok.op == OP_WRITE) && (in_tok.idx == slot_id);

	always_comb begin
		pe       = (prefix_q > cfg.eff_w) ? cfg.eff_w : prefix_q;
		shift    = cfg.eff_w - pe;
		cmp_mask = cfg.prefix_mode ? (cfg.kmask & ({KEY_W{1'b1}} << shift)) : cfg.kmask;
		match    = (((in_tok.key ^ key_q) & cmp_mask) == '0);
		take     = (in_tok.op == OP_CLASSIFY) && valid_q && match &&
		           (!in_tok.flag || (cfg.prefix_mode && (pe > in_tok.len)));
		nxt_tok  = in_tok;
		if (take) begin
			nxt_tok.flag = 1'b1;
			nxt_tok.len  = pe;
			nxt_tok.bits = bits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			if (wr_hit) begin
				valid_q <= in_tok.flag;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= nxt_tok;
		if (wr_hit) begin
			key_q    <= in_tok.key;
			prefix_q <= in_tok.len;
			bits_q   <= in_tok.bits;
		end
	end

	assign out_vld = vld_s1;
	assign out_tok = tok_s1;

endmodule

// ===== rtl/bfm_result.sv =====
// result stage: applies the winning rule or the wildcard and forms the verdict
module bfm_result (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wildcard_enable,
	input  logic [bfm_pkg::CLASS_BITS-1:0] wildcard_bits,
	input  logic                          in_vld,
	input  bfm_pkg::token_t               in_tok,
	output logic                          done,
	output logic [bfm_pkg::CLASS_BITS-1:0] class_bits,
	output bfm_pkg::verdict_t             verdict,
	output logic                          used_wildcard
);
	import bfm_pkg::*;

	logic                   done_q;
	logic [CLASS_BITS-1:0]  class_q;
	verdict_t               verdict_q;
	logic                   wild_q;

	logic [CLASS_BITS-1:0]  r;
	logic [CLASS_BITS-1:0]  nxt_class;
	verdict_t               nxt_verdict;
	logic                   nxt_wild;

	always_comb begin
		r           = '0;
		nxt_class   = '0;
		nxt_verdict = VERDICT_WRITTEN;
		nxt_wild    = 1'b0;
		if (in_tok.op == OP_CLASSIFY) begin
			if (in_tok.flag) begin
				r = in_tok.pbits & in_tok.bits;
			end else if (wildcard_enable) begin
				r        = in_tok.pbits & wildcard_bits;
				nxt_wild = 1'b1;
			end
			if (in_tok.flag || wildcard_enable) begin
				nxt_class   = r;
				nxt_verdict = (r == '0) ? VERDICT_EMPTY : VERDICT_CONTINUE;
			end else begin
				nxt_class   = in_tok.pbits;
				nxt_verdict = VERDICT_NO_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		class_q   <= nxt_class;
		verdict_q <= nxt_verdict;
		wild_q    <= nxt_wild;
	end

	assign done          = done_q;
	assign class_bits    = class_q;
	assign verdict       = verdict_q;
	assign used_wildcard = wild_q;

endmodule

// ===== rtl/bitvector_field_matcher_stage.sv =====
// top level: configuration registers, chain of rule cells and result stage
// an item passes one rule cell per clock, RULE_SLOTS cells in a row, then the result register
// done is driven by the result register and rises once the start transfer has passed every rule cell
// throughput: one item per cycle, busy stays low; results cannot be held off
// writes and lookups keep their order as they travel the same chain
// reset clears the slot valid marks and configuration (key_width 32, others 0)
module bitvector_field_matcher_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [63:0]                    key_value,
	input  logic [63:0]                    packet_bits,
	input  logic [4:0]                     entry_index,
	input  logic                           entry_valid,
	input  logic [63:0]                    rule_key,
	input  logic [6:0]                     rule_prefix,
	input  logic [63:0]                    rule_bits,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data,
	output logic                           done,
	output logic [63:0]                    class_bits,
	output logic [1:0]                     verdict,
	output logic                           used_wildcard
);
	import bfm_pkg::*;

	logic                   prefix_mode_q;
	logic [LEN_W-1:0]       key_width_q;
	logic                   wildcard_enable_q;
	logic [CLASS_BITS-1:0]  wildcard_bits_q;

	match_cfg_t             mcfg;
	logic [LEN_W-1:0]       eff_w;
	logic                   cfg_we;
	logic                   accept;
	token_t                 head_tok;

	logic                   chain_vld [RULE_SLOTS+1];
	token_t                 chain_tok [RULE_SLOTS+1];

	logic [CLASS_BITS-1:0]  res_class;
	verdict_t               res_verdict;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_mode_q     <= 1'b0;
			key_width_q       <= KEY_W_RESET;
			wildcard_enable_q <= 1'b0;
			wildcard_bits_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREFIX_MODE:     prefix_mode_q     <= cfg_data[0];
				REG_KEY_WIDTH:       key_width_q       <= cfg_data[LEN_W-1:0];
				REG_WILDCARD_ENABLE: wildcard_enable_q <= cfg_data[0];
				REG_WILDCARD_BITS:   wildcard_bits_q   <= cfg_data[CLASS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (key_width_q == '0) begin
			eff_w = LEN_W'(1);
		end else if (key_width_q > KEY_W_MAX) begin
			eff_w = KEY_W_MAX;
		end else begin
			eff_w = key_width_q;
		end
		mcfg.prefix_mode = prefix_mode_q;
		mcfg.eff_w       = eff_w;
		mcfg.kmask       = (eff_w >= KEY_W_MAX) ? {KEY_W{1'b1}} :
		                   ((KEY_W'(1) << eff_w) - KEY_W'(1));
	end

	always_comb begin
		head_tok.op    = op_t'(op);
		head_tok.idx   = SLOT_W'(entry_index);
		head_tok.pbits = packet_bits[CLASS_BITS-1:0];
		if (op_t'(op) == OP_WRITE) begin
			head_tok.flag = entry_valid;
			head_tok.key  = rule_key;
			head_tok.len  = rule_prefix;
			head_tok.bits = rule_bits[CLASS_BITS-1:0];
		end else begin
			head_tok.flag = 1'b0;
			head_tok.key  = key_value & mcfg.kmask;
			head_tok.len  = '0;
			head_tok.bits = '0;
		end
	end

	assign chain_vld[0] = accept;
	assign chain_tok[0] = head_tok;

	for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
		bfm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot_id (SLOT_W'(i)),
			.cfg     (mcfg),
			.in_vld  (chain_vld[i]),
			.in_tok  (chain_tok[i]),
			.out_vld (chain_vld[i+1]),
			.out_tok (chain_tok[i+1])
		);
	end

	bfm_result u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.wildcard_enable (wildcard_enable_q),
		.wildcard_bits   (wildcard_bits_q),
		.in_vld          (chain_vld[RULE_SLOTS]),
		.in_tok          (chain_tok[RULE_SLOTS]),
		.done            (done),
		.class_bits      (res_class),
		.verdict         (res_verdict),
		.used_wildcard   (used_wildcard)
	);

	assign class_bits = 64'(res_class);
	assign verdict    = res_verdict;

endmodule
